// ----- rtl/core/bpa_pkg.sv -----
// bpa_pkg: sizes, command and status codes, and the controller/datapath
// interface structs of the bitmap page allocator
// depends on nothing; used by every module of the block except bpa_ram
`timescale 1ns / 1ps

package bpa_pkg;

   // bitmap geometry
   localparam int NUM_PAGES  = 4096;
   localparam int WORD_BITS  = 64;
   localparam int PAGE_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = $clog2(PAGE_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);

   // field widths
   localparam int PAGE_W  = 12;
   localparam int COUNT_W = 13;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   // page count after reset
   localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = COUNT_W'(4096);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_MARK    = 2'd2,
      CMD_RESERVE = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_OOM   = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_SAME  = 2'd3
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       advance;
      logic       write;
      logic       cnt_up;
      logic       cnt_down;
      logic       respond;
      status_type status;
   } ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      cmd_type command;
      logic    past_limit;
      logic    hit;
      logic    last_word;
      logic    out_of_range;
      logic    bit_used;
   } stat_type;

endpackage

// ----- rtl/core/bpa_ram.sv -----
// bpa_ram: generic single write port, single read port RAM with registered read
// depends on nothing
`timescale 1ns / 1ps

module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
// bpa_ctrl: controller state machine of the bitmap page allocator
// depends on bpa_pkg for the command/status structs and codes
`timescale 1ns / 1ps

module bpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  bpa_pkg::stat_type stat,
   output bpa_pkg::ctrl_type ctrl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      ctrl.status  = bpa_pkg::STAT_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.command == bpa_pkg::CMD_ALLOC) begin
               // first fit scan, one word per cycle
               priority if (stat.past_limit) begin
                  ctrl.respond = 1'b1;
                  ctrl.status  = bpa_pkg::STAT_OOM;
               end else if (stat.hit) begin
                  ctrl.write    = 1'b1;
                  ctrl.cnt_down = 1'b1;
                  ctrl.respond  = 1'b1;
               end else if (stat.last_word) begin
                  ctrl.respond = 1'b1;
                  ctrl.status  = bpa_pkg::STAT_OOM;
               end else begin
                  ctrl.advance = 1'b1;
               end
            end else begin
               ctrl.respond = 1'b1;
               priority if (stat.out_of_range) begin
                  ctrl.status = bpa_pkg::STAT_RANGE;
               end else if (stat.command == bpa_pkg::CMD_RESERVE) begin
                  if (stat.bit_used) begin
                     ctrl.status = bpa_pkg::STAT_SAME;
                  end else begin
                     ctrl.write    = 1'b1;
                     ctrl.cnt_down = 1'b1;
                  end
               end else begin
                  // free and mark usable: already free is flagged, not counted
                  if (!stat.bit_used) begin
                     ctrl.status = bpa_pkg::STAT_SAME;
                  end else begin
                     ctrl.write  = 1'b1;
                     ctrl.cnt_up = 1'b1;
                  end
               end
            end
            if (ctrl.respond) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= ctrl.respond;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/bpa_datapath.sv -----
// bpa_datapath: bitmap RAM with per-word valid bits, free counter, page count
// register, word scan logic and result registers
// depends on bpa_pkg and bpa_ram
`timescale 1ns / 1ps

module bpa_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bpa_pkg::CMD_W-1:0]    req_command,
   input  logic [bpa_pkg::PAGE_W-1:0]   req_page_index,
   input  logic                         csr_write,
   input  logic [bpa_pkg::COUNT_W-1:0]  csr_page_count,
   input  bpa_pkg::ctrl_type            ctrl,
   output bpa_pkg::stat_type            stat,
   output logic [bpa_pkg::STAT_W-1:0]   rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]   rsp_result_page,
   output logic [bpa_pkg::COUNT_W-1:0]  rsp_free_count
);

   localparam int WADDR_W   = bpa_pkg::WADDR_W;
   localparam int BIT_W     = bpa_pkg::BIT_W;
   localparam int WORD_BITS = bpa_pkg::WORD_BITS;
   localparam int COUNT_W   = bpa_pkg::COUNT_W;
   localparam int PAGE_W    = bpa_pkg::PAGE_W;

   bpa_pkg::cmd_type            cmd_ff;
   logic [PAGE_W-1:0]           idx_ff;
   logic [WADDR_W-1:0]          word_addr_ff, word_addr_in;
   logic [COUNT_W-1:0]          page_count_ff;
   logic [COUNT_W-1:0]          free_total_ff, free_total_in;
   logic [bpa_pkg::PAGE_WORDS-1:0] vld_ff;
   logic                        rd_valid_ff;
   logic [bpa_pkg::STAT_W-1:0]  rsp_status_ff;
   logic [PAGE_W-1:0]           rsp_page_ff;
   logic [COUNT_W-1:0]          rsp_count_ff;

   logic [WADDR_W-1:0]          rd_addr;
   logic [WORD_BITS-1:0]        ram_q;
   logic [WORD_BITS-1:0]        rd_word;
   logic [WORD_BITS-1:0]        wr_word;
   logic [COUNT_W-1:0]          limit;
   logic [COUNT_W-1:0]          word_base;
   logic [COUNT_W-1:0]          avail;
   logic [WORD_BITS-1:0]        valid_mask;
   logic [WORD_BITS-1:0]        free_bits;
   logic [BIT_W-1:0]            first_bit;
   logic [BIT_W-1:0]            bit_sel;
   logic [WORD_BITS-1:0]        bit_onehot;
   logic [PAGE_W-1:0]           page_out;

   // read address: next word when the scan advances, else the current word
   assign rd_addr = ctrl.advance ? word_addr_ff + WADDR_W'(1) : word_addr_ff;

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (bpa_pkg::PAGE_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ctrl.write),
      .wr_addr (word_addr_ff),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // words never written read as all used
   assign rd_word = rd_valid_ff ? ram_q : '1;

   // effective limit saturates at the number of frames
   assign limit = (page_count_ff > COUNT_W'(bpa_pkg::NUM_PAGES))
                  ? COUNT_W'(bpa_pkg::NUM_PAGES) : page_count_ff;
   assign word_base = COUNT_W'({word_addr_ff, {BIT_W{1'b0}}});
   assign avail     = limit - word_base;

   // free pages of this word that lie below the limit
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = (COUNT_W'(b) < avail);
      end
   end
   assign free_bits = ~rd_word & valid_mask;

   // lowest free bit
   always_comb begin
      first_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            first_bit = BIT_W'(b);
         end
      end
   end

   // bit to change and the word written back
   assign bit_sel    = (cmd_ff == bpa_pkg::CMD_ALLOC) ? first_bit : idx_ff[BIT_W-1:0];
   assign bit_onehot = WORD_BITS'(1) << bit_sel;
   always_comb begin
      if (cmd_ff == bpa_pkg::CMD_ALLOC || cmd_ff == bpa_pkg::CMD_RESERVE) begin
         wr_word = rd_word | bit_onehot;
      end else begin
         wr_word = rd_word & ~bit_onehot;
      end
   end

   // status to the controller
   always_comb begin
      stat.command      = cmd_ff;
      stat.past_limit   = (word_base >= limit);
      stat.hit          = |free_bits;
      stat.last_word    = (word_addr_ff == WADDR_W'(bpa_pkg::PAGE_WORDS - 1));
      stat.out_of_range = (COUNT_W'(idx_ff) >= limit);
      stat.bit_used     = rd_word[idx_ff[BIT_W-1:0]];
   end

   // free count update
   always_comb begin
      free_total_in = free_total_ff;
      priority if (ctrl.cnt_up) begin
         free_total_in = free_total_ff + COUNT_W'(1);
      end else if (ctrl.cnt_down && free_total_ff != '0) begin
         free_total_in = free_total_ff - COUNT_W'(1);
      end
   end

   // page reported with the result
   always_comb begin
      priority if (ctrl.status == bpa_pkg::STAT_OOM) begin
         page_out = '0;
      end else if (cmd_ff == bpa_pkg::CMD_ALLOC) begin
         page_out = PAGE_W'({word_addr_ff, first_bit});
      end else begin
         page_out = idx_ff;
      end
   end

   // word address of the transaction
   always_comb begin
      word_addr_in = word_addr_ff;
      priority if (ctrl.load) begin
         word_addr_in = (bpa_pkg::cmd_type'(req_command) == bpa_pkg::CMD_ALLOC)
                        ? '0 : WADDR_W'(req_page_index[PAGE_W-1:BIT_W]);
      end else if (ctrl.advance) begin
         word_addr_in = word_addr_ff + WADDR_W'(1);
      end
   end

   // control state: valid bits, counter, page count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         free_total_ff <= '0;
         page_count_ff <= bpa_pkg::PAGE_COUNT_RESET;
      end else begin
         if (ctrl.write) begin
            vld_ff[word_addr_ff] <= 1'b1;
         end
         rd_valid_ff   <= vld_ff[rd_addr];
         free_total_ff <= free_total_in;
         if (csr_write) begin
            page_count_ff <= csr_page_count;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_addr_ff <= word_addr_in;
      if (ctrl.load) begin
         cmd_ff <= bpa_pkg::cmd_type'(req_command);
         idx_ff <= req_page_index;
      end
      if (ctrl.respond) begin
         rsp_status_ff <= ctrl.status;
         rsp_page_ff   <= page_out;
         rsp_count_ff  <= free_total_in;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_free_count  = rsp_count_ff;

endmodule

// ----- rtl/core/bitmap_page_allocator.sv -----
// bitmap_page_allocator: top level, first fit page frame allocator over a bitmap
// depends on bpa_pkg, bpa_ctrl, bpa_datapath (and bpa_ram below it)
`timescale 1ns / 1ps

// Usage
// A command (req_command, req_page_index) is taken at a rising edge with start
// high and busy low. Commands: allocate the lowest free page below page_count,
// free a page, mark a page usable, reserve a page.
// Each transaction returns one result, shown for exactly one cycle with
// rsp_valid high: rsp_status, rsp_result_page and rsp_free_count.
// The receiver cannot stall; results must be taken in the strobe cycle.
// From the accepting edge the controller passes through S_READ to S_EVAL. Free,
// mark and reserve answer in their first S_EVAL; allocate stays in S_EVAL and
// scans 1 to 64 bitmap words, one 64-bit word per cycle through the RAM read port.
// busy falls in the strobe cycle, so a new command can be taken at the edge that
// ends it.
// The page_count register is written on csr_valid (csr_ready is always high);
// the user must write it only while the block is idle; the block does not enforce it.
// Reset: every page reads as used (per-word valid bits cleared), the free count
// is zero and page_count is 4096; no clearing pass is needed.

module bitmap_page_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bpa_pkg::CMD_W-1:0]    req_command,
   input  logic [bpa_pkg::PAGE_W-1:0]   req_page_index,
   output logic                         rsp_valid,
   output logic [bpa_pkg::STAT_W-1:0]   rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]   rsp_result_page,
   output logic [bpa_pkg::COUNT_W-1:0]  rsp_free_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bpa_pkg::COUNT_W-1:0]  csr_page_count
);

   bpa_pkg::ctrl_type ctrl;
   bpa_pkg::stat_type stat;
   logic              csr_write;

   // configuration writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // controller
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // datapath
   bpa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_page_index  (req_page_index),
      .csr_write       (csr_write),
      .csr_page_count  (csr_page_count),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_result_page (rsp_result_page),
      .rsp_free_count  (rsp_free_count)
   );

`ifndef ASSERT_OFF
   // the result strobe comes as the block returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // free count never exceeds the number of frames
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_count <= bpa_pkg::COUNT_W'(bpa_pkg::NUM_PAGES)))
      else $error("free count above number of frames");

   // a strobe needs a transaction in flight the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction");
`endif

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for the bitmap page allocator, with its own copy of
// the page bitmap and free count that predicts every result
// depends on bpa_pkg and bitmap_page_allocator
`timescale 1ns / 1ps

module tb_top;

   // one result of a page command
   typedef struct {
      bpa_pkg::status_type          status;
      logic [bpa_pkg::PAGE_W-1:0]   page;
      logic [bpa_pkg::COUNT_W-1:0]  count;
   } page_reply_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [bpa_pkg::CMD_W-1:0]     req_command = bpa_pkg::CMD_ALLOC;
   logic [bpa_pkg::PAGE_W-1:0]    req_page_index = '0;
   logic                          rsp_valid;
   logic [bpa_pkg::STAT_W-1:0]    rsp_status;
   logic [bpa_pkg::PAGE_W-1:0]    rsp_result_page;
   logic [bpa_pkg::COUNT_W-1:0]   rsp_free_count;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [bpa_pkg::COUNT_W-1:0]   csr_page_count = bpa_pkg::PAGE_COUNT_RESET;

   bitmap_page_allocator i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_page_index  (req_page_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_result_page (rsp_result_page),
      .rsp_free_count  (rsp_free_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_page_count  (csr_page_count)
   );

   always #10 clock = ~clock;

   // shadow bitmap (1 = used), free count and page count
   logic [bpa_pkg::NUM_PAGES-1:0] used_map = '1;
   int unsigned                   free_tally = 0;
   logic [bpa_pkg::COUNT_W-1:0]   page_limit_reg = bpa_pkg::PAGE_COUNT_RESET;

   page_reply_type replies_due[$];
   int             held_pages[$];
   bit             idle_gaps = 1'b1;
   int             errors = 0;
   int             n_sent = 0;
   int             n_alloc = 0;
   int             n_oom = 0;
   int             n_high = 0;
   int             n_settings = 0;

   task automatic report_mismatch(string what);
      $display("tb_top: mismatch at %0t ns: %s", $time, what);
      errors++;
   endtask

   // first fit allocator behaviour, updates the shadow state
   function automatic page_reply_type predict_page_command(bpa_pkg::cmd_type cmd,
                                                           logic [bpa_pkg::PAGE_W-1:0] idx);
      page_reply_type r;
      int             lim;
      lim      = (page_limit_reg > bpa_pkg::NUM_PAGES) ? bpa_pkg::NUM_PAGES
                                                       : int'(page_limit_reg);
      r.status = bpa_pkg::STAT_OK;
      r.page   = idx;
      if (cmd == bpa_pkg::CMD_ALLOC) begin
         r.status = bpa_pkg::STAT_OOM;
         r.page   = '0;
         for (int p = 0; p < lim; p++) begin
            if (!used_map[p]) begin
               used_map[p] = 1'b1;
               if (free_tally > 0) free_tally--;
               r.status = bpa_pkg::STAT_OK;
               r.page   = bpa_pkg::PAGE_W'(p);
               break;
            end
         end
      end else if (int'(idx) >= lim) begin
         r.status = bpa_pkg::STAT_RANGE;
      end else if (cmd == bpa_pkg::CMD_FREE || cmd == bpa_pkg::CMD_MARK) begin
         // double free or repeated mark is not counted again
         if (!used_map[idx]) begin
            r.status = bpa_pkg::STAT_SAME;
         end else begin
            used_map[idx] = 1'b0;
            free_tally++;
         end
      end else begin
         if (used_map[idx]) begin
            r.status = bpa_pkg::STAT_SAME;
         end else begin
            used_map[idx] = 1'b1;
            if (free_tally > 0) free_tally--;
         end
      end
      r.count = (free_tally > 8191) ? bpa_pkg::COUNT_W'(8191)
                                    : bpa_pkg::COUNT_W'(free_tally);
      return r;
   endfunction

   // issue one command; start is left high for a following transaction
   task automatic send_command(bpa_pkg::cmd_type cmd, logic [bpa_pkg::PAGE_W-1:0] idx);
      page_reply_type r;
      if (idle_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_page_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = predict_page_command(cmd, idx);
      replies_due.push_back(r);
      n_sent++;
      if (cmd == bpa_pkg::CMD_ALLOC) begin
         n_alloc++;
         if (r.status == bpa_pkg::STAT_OOM) n_oom++;
         if (r.status == bpa_pkg::STAT_OK) begin
            held_pages.push_back(int'(r.page));
            if (r.page >= 2048) n_high++;
         end
      end
   endtask

   // drop start and wait for every outstanding result
   task automatic wait_idle();
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_page_count(logic [bpa_pkg::COUNT_W-1:0] value);
      wait_idle();
      csr_page_count <= value;
      csr_valid      <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid      <= 1'b0;
      page_limit_reg = value;
      n_settings++;
   endtask

   // result checker: every strobe is a transaction that cannot be held off
   always @(posedge clock) begin : check_replies
      page_reply_type want;
      if (!reset && rsp_valid) begin
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("result with none pending (page %0d)",
                                      rsp_result_page));
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_status, want.status));
            if (rsp_result_page !== want.page)
               report_mismatch($sformatf("result_page got %0d want %0d",
                                         rsp_result_page, want.page));
            if (rsp_free_count !== want.count)
               report_mismatch($sformatf("free_count got %0d want %0d",
                                         rsp_free_count, want.count));
         end
      end
   end

   // everything used after reset
   task automatic test_reset_state();
      send_command(bpa_pkg::CMD_ALLOC, 12'd0);
      send_command(bpa_pkg::CMD_RESERVE, 12'd0);
      send_command(bpa_pkg::CMD_RESERVE, 12'd4095);
   endtask

   // repeated mark, double free, repeated reserve, out of memory
   task automatic test_mark_and_free();
      send_command(bpa_pkg::CMD_MARK, 12'd0);
      send_command(bpa_pkg::CMD_MARK, 12'd0);
      send_command(bpa_pkg::CMD_FREE, 12'd0);
      send_command(bpa_pkg::CMD_MARK, 12'd4095);
      send_command(bpa_pkg::CMD_ALLOC, 12'd0);
      send_command(bpa_pkg::CMD_ALLOC, 12'd4095);
      send_command(bpa_pkg::CMD_ALLOC, 12'd0);
      send_command(bpa_pkg::CMD_FREE, 12'd4095);
      send_command(bpa_pkg::CMD_FREE, 12'd4095);
      send_command(bpa_pkg::CMD_RESERVE, 12'd4095);
      send_command(bpa_pkg::CMD_RESERVE, 12'd4095);
   endtask

   // word boundary, then a lowered page count hiding a counted free page
   task automatic test_word_edges();
      send_command(bpa_pkg::CMD_MARK, 12'd63);
      send_command(bpa_pkg::CMD_MARK, 12'd64);
      write_page_count(13'd64);
      send_command(bpa_pkg::CMD_ALLOC, 12'd4095);
      send_command(bpa_pkg::CMD_ALLOC, 12'd0);
      send_command(bpa_pkg::CMD_MARK, 12'd64);
      send_command(bpa_pkg::CMD_FREE, 12'd4095);
      send_command(bpa_pkg::CMD_RESERVE, 12'd63);
   endtask

   // page count of zero, and above the bitmap size (saturates)
   task automatic test_limit_extremes();
      write_page_count(13'd0);
      send_command(bpa_pkg::CMD_ALLOC, 12'd0);
      send_command(bpa_pkg::CMD_MARK, 12'd0);
      write_page_count(13'd8191);
      send_command(bpa_pkg::CMD_ALLOC, 12'd0);
      send_command(bpa_pkg::CMD_MARK, 12'd2048);
      send_command(bpa_pkg::CMD_RESERVE, 12'd2048);
   endtask

   // random traffic under one page count; frees mostly hit allocated pages
   task automatic test_random_traffic(int items, logic [bpa_pkg::COUNT_W-1:0] limit_value,
                                      int lo, int hi, int alloc_pct);
      bpa_pkg::cmd_type           cmd;
      logic [bpa_pkg::PAGE_W-1:0] idx;
      int                         roll;
      int                         k;
      write_page_count(limit_value);
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct) begin
            cmd = bpa_pkg::CMD_ALLOC;
         end else begin
            roll = $urandom_range(0, 99);
            cmd  = (roll < 40) ? bpa_pkg::CMD_FREE :
                   (roll < 75) ? bpa_pkg::CMD_MARK : bpa_pkg::CMD_RESERVE;
         end
         if (cmd == bpa_pkg::CMD_FREE && held_pages.size() != 0
             && $urandom_range(0, 9) < 7) begin
            k   = $urandom_range(0, held_pages.size() - 1);
            idx = bpa_pkg::PAGE_W'(held_pages[k]);
            held_pages.delete(k);
         end else if ($urandom_range(0, 9) == 0) begin
            idx = bpa_pkg::PAGE_W'($urandom_range(0, 4095));
         end else begin
            idx = bpa_pkg::PAGE_W'($urandom_range(lo, hi));
         end
         send_command(cmd, idx);
         // occasionally let the block drain completely
         if (idle_gaps && $urandom_range(0, 49) == 0) wait_idle();
      end
   endtask

   initial begin : run_tests
      int lim_r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_mark_and_free();
      test_word_edges();
      test_limit_extremes();
      test_random_traffic(120, 13'd200, 0, 199, 30);
      // free pages near the top force long scans
      test_random_traffic(100, 13'd4096, 3840, 4095, 25);
      lim_r = $urandom_range(1, 8191);
      test_random_traffic(100, bpa_pkg::COUNT_W'(lim_r), 0,
                          ((lim_r > 4096) ? 4096 : lim_r) - 1, 35);
      test_random_traffic(100, 13'd8191, 0, 4095, 30);
      test_random_traffic(100, 13'd64, 0, 63, 40);
      test_random_traffic(20, 13'd0, 0, 4095, 30);
      test_random_traffic(20, 13'd1, 0, 1, 40);
      // back to back to the end
      idle_gaps = 1'b0;
      test_random_traffic(140, 13'd4096, 0, 511, 35);
      wait_idle();
      repeat (70) @(posedge clock);
      if (replies_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", replies_due.size()));
      $display("tb_top: %0d commands, %0d allocations (%0d out of memory, %0d above page 2047)",
               n_sent, n_alloc, n_oom, n_high);
      $display("tb_top: %0d page_count writes, %0d pages free at the end",
               n_settings, free_tally);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin : watchdog
      #20_000_000;
      $display("tb_top: timeout");
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
